FILE: hw/rtl/set_pkg.sv
// Shared types, constants and helpers for the Sobel edge threshold block.
// Used by the front end, the queue, the back end and the top level.
package set_pkg;

    localparam int LB_DEPTH   = 512;
    localparam int COL_W      = 9;
    localparam int WIDTH_W    = 10;
    localparam int THR_W      = 11;
    localparam int LIM2_W     = 22;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 20;
    localparam int LB_W       = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;
    localparam int Q_CW       = 3;

    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 10'd3;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 10'd512;
    localparam logic [WIDTH_W-1:0] WIDTH_RST   = 10'd488;
    localparam logic [THR_W-1:0]   THR_RST     = 11'd220;
    localparam logic [COL_W-1:0]   ROW_LAST    = 9'd511;
    localparam logic [23:0]        WHITE_RGB   = 24'hFFFFFF;
    localparam logic [23:0]        BLACK_RGB   = 24'h000000;

    // APB register indexes (paddr[2])
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_THRESHOLD  = 1'b1;

    // One window column: [0] row above-above, [1] row above, [2] current row
    typedef logic [2:0][7:0] t_col;

    typedef struct packed {
        t_col [2:0]       win;   // [0] oldest column, [2] newest column
        logic [COL_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_win_item;

    // (r+g+b)/3 as multiply by 683/2048; exact for sums up to 765
    function automatic logic [7:0] gray_of(input logic [23:0] rgb);
        logic [19:0] s;
        logic [19:0] p;
        begin
            s = 20'(rgb[23:16]) + 20'(rgb[15:8]) + 20'(rgb[7:0]);
            p = s * 20'd683;
            return p[18:11];
        end
    endfunction

endpackage

FILE: hw/rtl/sobel_edge_threshold_top.sv
// Top level of the Sobel edge threshold block: APB registers and stream ports.
// Depends on set_pkg, set_front, set_queue and set_back.
//
// Takes one RGB pixel per clock in raster order and gives one black/white result
// per interior pixel, one clock per pixel sustained as long as results are taken.
// A result follows the pixel to its lower right: the window stage registers the
// accepted pixel, the queue is written from it, then the gradient, square and
// threshold compare stages each register in turn. The two previous gray rows live
// in one 512 x 16 RAM read and written once per pixel; its contents are undefined
// after reset and need no clearing, since a row is always written before it is
// read. A four-entry queue separates the window logic from the arithmetic, so
// s_axis_tready drops only when that queue, counting the pixel in the window stage,
// fills under output backpressure. Border pixels give no result.
module sobel_edge_threshold_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] pixel_color
    input  logic        s_axis_tuser,   // [0] frame_start
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [23:0] result_color, [32:24] center_row,
                                        // [41:33] center_col, [47:42] zero
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [set_pkg::WIDTH_W-1:0] r_line_width;
    logic [set_pkg::THR_W-1:0]   r_threshold;
    logic [set_pkg::WIDTH_W-1:0] width;
    logic                        cfg_wr;

    logic                        push;
    set_pkg::t_win_item          push_item;
    logic                        q_valid;
    set_pkg::t_win_item          q_item;
    logic                        q_pop;
    logic [set_pkg::Q_CW-1:0]    q_count;

    logic [23:0]                 res_color;
    logic [set_pkg::COL_W-1:0]   res_row;
    logic [set_pkg::COL_W-1:0]   res_col;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= set_pkg::WIDTH_RST;
            r_threshold  <= set_pkg::THR_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == set_pkg::REG_LINE_WIDTH) begin
                r_line_width <= pwdata[set_pkg::WIDTH_W-1:0];
            end else begin
                r_threshold <= pwdata[set_pkg::THR_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == set_pkg::REG_THRESHOLD) begin
            prdata = {{(32 - set_pkg::THR_W){1'b0}}, r_threshold};
        end else begin
            prdata = {{(32 - set_pkg::WIDTH_W){1'b0}}, r_line_width};
        end
    end

    // clamp the row width to the supported range
    always_comb begin
        priority if (r_line_width > set_pkg::WIDTH_MAX) begin
            width = set_pkg::WIDTH_MAX;
        end else if (r_line_width < set_pkg::WIDTH_MIN) begin
            width = set_pkg::WIDTH_MIN;
        end else begin
            width = r_line_width;
        end
    end

    set_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_pixel_color (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_width       (width),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_item        (push_item)
    );

    set_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    set_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .i_threshold    (r_threshold),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_result_color (res_color),
        .o_center_row   (res_row),
        .o_center_col   (res_col)
    );

    assign m_axis_tdata = {6'b0, res_col, res_row, res_color};

endmodule

FILE: hw/rtl/set_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module set_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/set_front.sv
// Front end: pixel intake, row/column tracking, line buffers and 3x3 window.
// Depends on set_pkg and set_ram; pushes interior-pixel windows to the queue.
module set_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [23:0]                   i_pixel_color,
    input  logic                          i_frame_start,
    input  logic [set_pkg::WIDTH_W-1:0]   i_width,
    input  logic [set_pkg::Q_CW-1:0]      i_q_count,
    output logic                          o_push,
    output set_pkg::t_win_item            o_item
);

    logic                        acc;
    logic [set_pkg::COL_W-1:0]   col_raw;
    logic [set_pkg::COL_W-1:0]   cur_col;
    logic [set_pkg::COL_W-1:0]   cur_row;
    logic [set_pkg::WIDTH_W-1:0] col_inc;

    logic [set_pkg::COL_W-1:0]   r_col, n_col;
    logic [set_pkg::COL_W-1:0]   r_row, n_row;

    logic                        r_s1_v;
    logic [23:0]                 r_s1_pix;
    logic [set_pkg::COL_W-1:0]   r_s1_col;
    logic [set_pkg::COL_W-1:0]   r_s1_row;
    logic                        r_s1_emit;
    logic                        r_s1_byp;
    logic [set_pkg::LB_W-1:0]    r_s1_fwd;

    logic [set_pkg::LB_W-1:0]    ram_rdata;
    logic [set_pkg::LB_W-1:0]    line_data;
    logic [set_pkg::LB_W-1:0]    wdata;
    logic [7:0]                  gray;

    set_pkg::t_col [2:0]         r_win;
    set_pkg::t_col [2:0]         n_win;

    assign o_ready = ({1'b0, i_q_count} + {{set_pkg::Q_CW{1'b0}}, r_s1_v})
                     < (set_pkg::Q_CW + 1)'(set_pkg::Q_DEPTH);
    assign acc     = i_valid && o_ready;

    always_comb begin
        col_raw = i_frame_start ? '0 : r_col;
        cur_row = i_frame_start ? '0 : r_row;
        cur_col = ({1'b0, col_raw} >= i_width) ? '0 : col_raw;
        col_inc = {1'b0, cur_col} + 10'd1;
        if (col_inc >= i_width) begin
            n_col = '0;
            n_row = (cur_row != set_pkg::ROW_LAST) ? cur_row + 9'd1 : cur_row;
        end else begin
            n_col = col_inc[set_pkg::COL_W-1:0];
            n_row = cur_row;
        end
    end

    // Stage 1: line buffer data is back; forward the previous write on same column
    assign gray      = set_pkg::gray_of(r_s1_pix);
    assign line_data = r_s1_byp ? r_s1_fwd : ram_rdata;
    assign wdata     = {line_data[7:0], gray};

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = {gray, line_data[7:0], line_data[15:8]};
    end

    set_ram #(
        .WIDTH (set_pkg::LB_W),
        .DEPTH (set_pkg::LB_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_col),
        .i_wdata (wdata),
        .i_re    (acc),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_win  <= '0;
        end else begin
            r_s1_v <= acc;
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_s1_v) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix  <= i_pixel_color;
            r_s1_col  <= cur_col;
            r_s1_row  <= cur_row;
            r_s1_emit <= (cur_row >= 9'd2) && (cur_col >= 9'd2);
            r_s1_byp  <= r_s1_v && (r_s1_col == cur_col);
            r_s1_fwd  <= wdata;
        end
    end

    assign o_push      = r_s1_v && r_s1_emit;
    assign o_item.win  = n_win;
    assign o_item.row  = r_s1_row - 9'd1;
    assign o_item.col  = r_s1_col - 9'd1;

endmodule

FILE: hw/rtl/set_queue.sv
// Short queue of window items between the front end and the back end.
// Depends on set_pkg; the front end never pushes into a full queue.
module set_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  set_pkg::t_win_item        i_item,
    input  logic                      i_pop,
    output logic                      o_valid,
    output set_pkg::t_win_item        o_item,
    output logic [set_pkg::Q_CW-1:0]  o_count
);

    set_pkg::t_win_item            r_mem [set_pkg::Q_DEPTH];
    logic [set_pkg::Q_AW-1:0]      r_wptr;
    logic [set_pkg::Q_AW-1:0]      r_rptr;
    logic [set_pkg::Q_CW-1:0]      r_count;
    logic                          do_pop;

    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + {{(set_pkg::Q_CW-1){1'b0}}, i_push}
                               - {{(set_pkg::Q_CW-1){1'b0}}, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

FILE: hw/rtl/set_back.sv
// Back end: Sobel gradients, squared magnitude, threshold and output register.
// Depends on set_pkg; three stages that advance independently under backpressure.
module set_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  set_pkg::t_win_item          i_item,
    output logic                        o_pop,
    input  logic [set_pkg::THR_W-1:0]   i_threshold,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [23:0]                 o_result_color,
    output logic [set_pkg::COL_W-1:0]   o_center_row,
    output logic [set_pkg::COL_W-1:0]   o_center_col
);

    logic adv1, adv2, adv3;

    logic [9:0] sum_right, sum_left, sum_top, sum_bot;
    logic signed [set_pkg::GRAD_W-1:0] gx, gy;
    logic signed [2*set_pkg::GRAD_W-1:0] px, py;
    logic [2*set_pkg::THR_W-1:0] lim2_full;
    logic [set_pkg::LIM2_W-1:0] mag2;

    logic                              r_v1, r_v2, r_v3;
    logic signed [set_pkg::GRAD_W-1:0] r_gx, r_gy;
    logic [set_pkg::COL_W-1:0]         r_row1, r_col1, r_row2, r_col2, r_row3, r_col3;
    logic [set_pkg::SQ_W-1:0]          r_sqx, r_sqy;
    logic [set_pkg::LIM2_W-1:0]        r_lim2;
    logic [23:0]                       r_color;

    assign adv3  = !r_v3 || i_ready;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    assign o_pop = i_valid && adv1;

    always_comb begin
        sum_right = 10'(i_item.win[2][0]) + {1'b0, i_item.win[2][1], 1'b0}
                  + 10'(i_item.win[2][2]);
        sum_left  = 10'(i_item.win[0][0]) + {1'b0, i_item.win[0][1], 1'b0}
                  + 10'(i_item.win[0][2]);
        sum_top   = 10'(i_item.win[0][0]) + {1'b0, i_item.win[1][0], 1'b0}
                  + 10'(i_item.win[2][0]);
        sum_bot   = 10'(i_item.win[0][2]) + {1'b0, i_item.win[1][2], 1'b0}
                  + 10'(i_item.win[2][2]);
        gx = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
        gy = $signed({1'b0, sum_top})   - $signed({1'b0, sum_bot});
        px = r_gx * r_gx;
        py = r_gy * r_gy;
        lim2_full = i_threshold * i_threshold;
        mag2 = (set_pkg::LIM2_W)'(r_sqx) + (set_pkg::LIM2_W)'(r_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim2 <= lim2_full[set_pkg::LIM2_W-1:0];
        if (adv1) begin
            r_gx   <= gx;
            r_gy   <= gy;
            r_row1 <= i_item.row;
            r_col1 <= i_item.col;
        end
        if (adv2) begin
            r_sqx  <= px[set_pkg::SQ_W-1:0];
            r_sqy  <= py[set_pkg::SQ_W-1:0];
            r_row2 <= r_row1;
            r_col2 <= r_col1;
        end
        if (adv3) begin
            r_color <= (mag2 < r_lim2) ? set_pkg::WHITE_RGB : set_pkg::BLACK_RGB;
            r_row3  <= r_row2;
            r_col3  <= r_col2;
        end
    end

    assign o_valid        = r_v3;
    assign o_result_color = r_color;
    assign o_center_row   = r_row3;
    assign o_center_col   = r_col3;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for sobel_edge_threshold_top: streams RGB frames, predicts each
// black/white edge mark in a scoreboard class and compares the output stream to it.
// Depends on set_pkg for register indexes, sizes and color constants.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 150;
    localparam int SHOW_LIMIT   = 40;

    // Predicts the edge marks for the pixels the block accepts and holds them in order
    class edge_map_predictor;
        logic [set_pkg::WIDTH_W-1:0] width_reg;
        logic [set_pkg::THR_W-1:0]   thr_reg;
        logic [7:0]         above_row[set_pkg::LB_DEPTH];
        logic [7:0]         above2_row[set_pkg::LB_DEPTH];
        int                 win[3][3];
        int unsigned        row_pos;
        int unsigned        col_pos;
        logic [47:0]        pending_marks[$];
        int                 errors;

        function new();
            width_reg = set_pkg::WIDTH_RST;
            thr_reg   = set_pkg::THR_RST;
            foreach (above_row[i]) begin
                above_row[i]  = '0;
                above2_row[i] = '0;
            end
            foreach (win[r, k]) win[r][k] = 0;
            row_pos = 0;
            col_pos = 0;
            errors  = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            case (idx)
                set_pkg::REG_LINE_WIDTH: width_reg = value[set_pkg::WIDTH_W-1:0];
                set_pkg::REG_THRESHOLD:  thr_reg   = value[set_pkg::THR_W-1:0];
            endcase
        endfunction

        function int pending();
            return pending_marks.size();
        endfunction

        function void take_pixel(logic [23:0] px, logic frame_start);
            int unsigned w;
            int unsigned c;
            int unsigned sum;
            int          gray;
            int          gx;
            int          gy;
            int          mag2;
            int          lim2;
            logic [23:0] color;
            w = width_reg;
            if (w > set_pkg::LB_DEPTH) w = set_pkg::LB_DEPTH;
            if (w < 3) w = 3;
            sum = px[23:16];
            sum += px[15:8];
            sum += px[7:0];
            gray = sum / 3;
            if (frame_start) begin
                row_pos = 0;
                col_pos = 0;
            end
            if (col_pos >= w) col_pos = 0;
            c = col_pos;
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = above2_row[c];
            win[1][2] = above_row[c];
            win[2][2] = gray;
            above2_row[c] = above_row[c];
            above_row[c]  = gray[7:0];
            if (row_pos >= 2 && c >= 2) begin
                gx = (win[0][2] + 2 * win[1][2] + win[2][2])
                   - (win[0][0] + 2 * win[1][0] + win[2][0]);
                gy = (win[0][0] + 2 * win[0][1] + win[0][2])
                   - (win[2][0] + 2 * win[2][1] + win[2][2]);
                mag2  = gx * gx + gy * gy;
                lim2  = int'(thr_reg) * int'(thr_reg);
                color = (mag2 < lim2) ? set_pkg::WHITE_RGB : set_pkg::BLACK_RGB;
                pending_marks.push_back({6'b0, 9'(c - 1), 9'(row_pos - 1), color});
            end
            if (c + 1 >= w) begin
                col_pos = 0;
                if (row_pos < set_pkg::ROW_LAST) row_pos++;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= SHOW_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_mark(logic [47:0] got);
            logic [47:0] want;
            if (pending_marks.size() == 0) begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = pending_marks.pop_front();
            if (got[23:0] !== want[23:0])
                report($sformatf("color %h, expected %h", got[23:0], want[23:0]));
            if (got[32:24] !== want[32:24])
                report($sformatf("row %0d, expected %0d", got[32:24], want[32:24]));
            if (got[41:33] !== want[41:33])
                report($sformatf("col %0d, expected %0d", got[41:33], want[41:33]));
            if (got[47:42] !== want[47:42])
                report($sformatf("pad bits %b not zero", got[47:42]));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [23:0] pixel_color
    logic        s_axis_tuser;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [23:0] result_color, [32:24] center_row, [41:33] center_col
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    edge_map_predictor edge_pred = new();

    bit tx_calm;
    bit hold_req;
    int tone;
    int marks_taken;

    logic [23:0] flat_px[3] = '{24'h030000, 24'h000102, 24'h010101};
    // {frame_start, pixel}: strong corner, then a frame restart in the middle of a row
    logic [24:0] ramp_px[13] = '{
        {1'b1, 24'hFFFFFF}, {1'b0, 24'hFFFFFF}, {1'b0, 24'hFFFFFF},
        {1'b0, 24'h000000}, {1'b0, 24'h000000}, {1'b0, 24'hFFFFFF},
        {1'b0, 24'h000000}, {1'b0, 24'h000000}, {1'b0, 24'hFFFFFF},
        {1'b0, 24'h7F7F7F}, {1'b1, 24'hFF0000}, {1'b0, 24'h00FF00},
        {1'b0, 24'h0000FF}
    };

    sobel_edge_threshold_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] rand_pixel();
        logic [23:0] px;
        int          ch;
        px = '0;
        case ($urandom_range(9))
            0:       px = set_pkg::BLACK_RGB;
            1:       px = set_pkg::WHITE_RGB;
            2, 3:    px = 24'($urandom());
            default: begin
                for (int k = 0; k < 3; k++) begin
                    ch = tone + $urandom_range(0, 8) - 4;
                    if (ch < 0) ch = 0;
                    if (ch > 255) ch = 255;
                    px[8*k +: 8] = ch[7:0];
                end
            end
        endcase
        return px;
    endfunction

    task automatic apb_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        edge_pred.set_reg(idx, value);
    endtask

    // upper bits carry noise that the block must ignore
    task automatic set_regs(logic [set_pkg::WIDTH_W-1:0] w, logic [set_pkg::THR_W-1:0] thr);
        logic [31:0] word;
        word = $urandom();
        word[set_pkg::WIDTH_W-1:0] = w;
        apb_write(set_pkg::REG_LINE_WIDTH, word);
        word = $urandom();
        word[set_pkg::THR_W-1:0] = thr;
        apb_write(set_pkg::REG_THRESHOLD, word);
    endtask

    task automatic send_pixel(logic [23:0] px, logic frame_start);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= frame_start;
        do @(posedge i_clk); while (!s_axis_tready);
        edge_pred.take_pixel(px, frame_start);
    endtask

    // drop valid, wait for every expected mark, then let the pipeline run dry
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (edge_pred.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_frames(int unsigned n, int unsigned fs_odds);
        logic [23:0] px;
        logic        fs;
        tx_calm = ($urandom_range(3) == 0);
        tone    = $urandom_range(255);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) tone = $urandom_range(255);
            px = rand_pixel();
            fs = (i == 0) || (fs_odds != 0 && $urandom_range(fs_odds - 1) == 0);
            send_pixel(px, fs);
        end
    endtask

    // output side: random stalls, calm stretches, and long hold-offs to fill the block
    initial begin
        int idle_left;
        int hold_left;
        int calm_left;
        int next_hold;
        bit rx_calm;
        idle_left   = 0;
        hold_left   = 0;
        calm_left   = 0;
        next_hold   = 150;
        rx_calm     = 1'b0;
        marks_taken = 0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                edge_pred.check_mark(m_axis_tdata);
                marks_taken++;
            end
            // hold off as soon as the requested run starts producing results
            if (hold_req && m_axis_tvalid) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (marks_taken >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold += 750;
            end
            if (calm_left == 0) begin
                rx_calm   = ($urandom_range(3) == 0);
                calm_left = $urandom_range(20, 200);
            end else begin
                calm_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                idle_left = rx_calm ? 0 : pick_gap();
            end
        end
    end

    initial begin
        logic [set_pkg::WIDTH_W-1:0] w;
        logic [set_pkg::THR_W-1:0]   thr;
        int unsigned        n;
        int unsigned        fs_odds;
        int unsigned        span;
        tx_calm       = 1'b0;
        hold_req      = 1'b0;
        tone          = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // width below minimum, zero threshold: a flat window sits exactly on the limit
        set_regs(10'd1, 11'd0);
        for (int i = 0; i < 9; i++) send_pixel(flat_px[i % 3], i == 0);
        settle();

        set_regs(10'd3, 11'd1443);
        foreach (ramp_px[i]) send_pixel(ramp_px[i][23:0], ramp_px[i][24]);
        settle();

        // narrow rows at full input rate while the receiver holds off: fill the block
        set_regs(10'd3, 11'($urandom_range(0, 500)));
        tx_calm  = 1'b1;
        tone     = $urandom_range(255);
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++) send_pixel(rand_pixel(), i == 0);
        settle();

        for (int p = 0; p < 10; p++) begin
            fs_odds = 150;
            thr = ($urandom_range(3) == 0) ? 11'($urandom_range(0, 2047))
                                           : 11'($urandom_range(0, 500));
            if ($urandom_range(9) == 0) w = 10'($urandom_range(0, 2));
            else w = 10'($urandom_range(3, 24));
            span = (w < 3) ? 3 : w;
            n = $urandom_range(3, 6) * span + $urandom_range(0, 2);
            case (p)
                4: begin
                    fs_odds = 0;
                    if ($urandom_range(1) == 0) begin
                        // widest row, and a value past the top that clamps to it
                        w = $urandom_range(1) ? 10'd1023 : set_pkg::WIDTH_MAX;
                        n = 2 * set_pkg::LB_DEPTH + $urandom_range(3, 60);
                    end else begin
                        // narrow rows long enough to pin the row counter at its top
                        w = 10'($urandom_range(0, 3));
                        n = 517 * 3 + $urandom_range(0, 2);
                    end
                end
                8: thr = 11'd2047;
                9: thr = 11'd0;
                default: ;
            endcase
            set_regs(w, thr);
            run_frames(n, fs_odds);
            settle();
        end

        if (edge_pred.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
